FILE: rtl/core/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the symmetrical components core
// Sample and coefficient formats, the per-opcode coefficient table and the
// coefficient set that drives one lane.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 16;
    // Q2.F signed: the unit coefficient needs two integer bits with sign
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    // five products are summed per result part
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int RND_BITS       = ACC_BITS - COEF_FRAC_BITS;
    localparam int NUM_LANES      = 3;
    // input register, product register, sum register, output register
    localparam int PIPE_DEPTH     = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic        [1:0]             opcode_t;

    localparam opcode_t OP_TO_SEQ     = 2'd0;
    localparam opcode_t OP_FROM_SEQ   = 2'd1;
    localparam opcode_t OP_TO_SCALED  = 2'd2;
    localparam opcode_t OP_FROM_SCALED = 2'd3;

    localparam sample_t SAMPLE_MAX = sample_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam sample_t SAMPLE_MIN = sample_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Round sqrt(p4 / (4 q)) to nearest: largest k with q*(2k-1)^2 <= p4
    function automatic longint round_sqrt(input longint p4, input longint q);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'sd1 <<< 26;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >>> 1;
            if (q * (2 * mid - 1) * (2 * mid - 1) <= p4)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    localparam longint COEF_UNIT = 64'sd1 <<< COEF_FRAC_BITS;
    localparam longint COEF_SQ   = 64'sd1 <<< (2 * COEF_FRAC_BITS);

    // Unit coefficient, one-third, alpha terms and sqrt3 scalings, rounded
    // to nearest in Q2.F
    localparam coef_t C_ONE       = coef_t'(COEF_UNIT);
    localparam coef_t C_THIRD     = coef_t'((2 * COEF_UNIT + 3) / 6);
    localparam coef_t C_SIXTH     = coef_t'((2 * COEF_UNIT + 6) / 12);
    localparam coef_t C_HALF      = coef_t'(COEF_UNIT >>> 1);
    localparam coef_t C_SQRT3_6   = coef_t'(round_sqrt(COEF_SQ, 3));
    localparam coef_t C_SQRT3_2   = coef_t'(round_sqrt(3 * COEF_SQ, 1));
    localparam coef_t C_SQRT3_3X2 = coef_t'(round_sqrt(COEF_SQ <<< 2, 3));

    // Matrix entries of one opcode: c1 on the first column and
    // the first row, w = wr + j*wi for the rotated entries
    typedef struct packed {
        coef_t c1;
        coef_t wr;
        coef_t wi;
    } coef_set_t;

    // Coefficients that one lane applies: a real weight on phase a and
    // complex weights on phases b and c
    typedef struct packed {
        coef_t a;
        coef_t b_re;
        coef_t b_im;
        coef_t c_re;
        coef_t c_im;
    } lane_coef_t;

    function automatic coef_set_t coef_lookup(input opcode_t op);
        coef_set_t cs;
        case (op)
            OP_TO_SEQ:
            begin
                cs.c1 = C_THIRD;
                cs.wr = -C_SIXTH;
                cs.wi = C_SQRT3_6;
            end
            OP_FROM_SEQ:
            begin
                cs.c1 = C_ONE;
                cs.wr = -C_HALF;
                cs.wi = -C_SQRT3_2;
            end
            OP_TO_SCALED:
            begin
                cs.c1 = C_SQRT3_3X2;
                cs.wr = -C_SQRT3_6;
                cs.wi = C_HALF;
            end
            default:
            begin
                cs.c1 = C_SQRT3_3X2;
                cs.wr = -C_SQRT3_6;
                cs.wi = -C_HALF;
            end
        endcase
        return cs;
    endfunction

endpackage

FILE: rtl/core/scs_lane.sv
// ----------------------------------------------------------------------------
// scs_lane: one output row of the 3x3 complex matrix product
// Multiplies the three phasors by the lane's weights, registers the products,
// then sums them into the unrounded real and imaginary accumulators.
// ----------------------------------------------------------------------------
module scs_lane (
    input  logic                clk,
    input  scs_pkg::sample_t    xr [3],
    input  scs_pkg::sample_t    xi [3],
    input  scs_pkg::lane_coef_t coef,
    output scs_pkg::acc_t       sum_re,
    output scs_pkg::acc_t       sum_im
);

    scs_pkg::prod_t p_ar_reg, p_ar_next;
    scs_pkg::prod_t p_ai_reg, p_ai_next;
    scs_pkg::prod_t p_b_rr_reg, p_b_rr_next;
    scs_pkg::prod_t p_b_ii_reg, p_b_ii_next;
    scs_pkg::prod_t p_b_ri_reg, p_b_ri_next;
    scs_pkg::prod_t p_b_ir_reg, p_b_ir_next;
    scs_pkg::prod_t p_c_rr_reg, p_c_rr_next;
    scs_pkg::prod_t p_c_ii_reg, p_c_ii_next;
    scs_pkg::prod_t p_c_ri_reg, p_c_ri_next;
    scs_pkg::prod_t p_c_ir_reg, p_c_ir_next;
    scs_pkg::acc_t  sum_re_reg, sum_re_next;
    scs_pkg::acc_t  sum_im_reg, sum_im_next;

    // Form the ten sample-by-coefficient products
    always_comb
    begin
        p_ar_next   = xr[0] * coef.a;
        p_ai_next   = xi[0] * coef.a;
        p_b_rr_next = xr[1] * coef.b_re;
        p_b_ii_next = xi[1] * coef.b_im;
        p_b_ri_next = xi[1] * coef.b_re;
        p_b_ir_next = xr[1] * coef.b_im;
        p_c_rr_next = xr[2] * coef.c_re;
        p_c_ii_next = xi[2] * coef.c_im;
        p_c_ri_next = xi[2] * coef.c_re;
        p_c_ir_next = xr[2] * coef.c_im;
    end

    // Sum the registered products exactly
    always_comb
    begin
        sum_re_next = scs_pkg::acc_t'(p_ar_reg)
                    + (scs_pkg::acc_t'(p_b_rr_reg) - scs_pkg::acc_t'(p_b_ii_reg))
                    + (scs_pkg::acc_t'(p_c_rr_reg) - scs_pkg::acc_t'(p_c_ii_reg));
        sum_im_next = scs_pkg::acc_t'(p_ai_reg)
                    + (scs_pkg::acc_t'(p_b_ri_reg) + scs_pkg::acc_t'(p_b_ir_reg))
                    + (scs_pkg::acc_t'(p_c_ri_reg) + scs_pkg::acc_t'(p_c_ir_reg));
    end

    // Advance the product and sum stages
    always_ff @(posedge clk)
    begin
        p_ar_reg   <= p_ar_next;
        p_ai_reg   <= p_ai_next;
        p_b_rr_reg <= p_b_rr_next;
        p_b_ii_reg <= p_b_ii_next;
        p_b_ri_reg <= p_b_ri_next;
        p_b_ir_reg <= p_b_ir_next;
        p_c_rr_reg <= p_c_rr_next;
        p_c_ii_reg <= p_c_ii_next;
        p_c_ri_reg <= p_c_ri_next;
        p_c_ir_reg <= p_c_ir_next;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
    end

    assign sum_re = sum_re_reg;
    assign sum_im = sum_im_reg;

endmodule

FILE: rtl/core/scs_merge.sv
// ----------------------------------------------------------------------------
// scs_merge: rounding, saturation and flag merge across the lanes
// Rounds each lane accumulator to sample precision, clips it to the sample
// range and combines the per-part clip flags into one saturated flag.
// ----------------------------------------------------------------------------
module scs_merge (
    input  logic             clk,
    input  scs_pkg::acc_t    sum_re [scs_pkg::NUM_LANES],
    input  scs_pkg::acc_t    sum_im [scs_pkg::NUM_LANES],
    output scs_pkg::sample_t res_re [scs_pkg::NUM_LANES],
    output scs_pkg::sample_t res_im [scs_pkg::NUM_LANES],
    output logic             saturated
);

    typedef logic signed [scs_pkg::RND_BITS-1:0] rnd_t;

    typedef struct packed {
        scs_pkg::sample_t value;
        logic             clip;
    } clip_res_t;

    localparam scs_pkg::acc_t ROUND_HALF =
        scs_pkg::acc_t'(64'sd1 <<< (scs_pkg::COEF_FRAC_BITS - 1));
    localparam rnd_t RND_MAX = rnd_t'(scs_pkg::SAMPLE_MAX);
    localparam rnd_t RND_MIN = rnd_t'(scs_pkg::SAMPLE_MIN);

    scs_pkg::sample_t res_re_reg [scs_pkg::NUM_LANES];
    scs_pkg::sample_t res_im_reg [scs_pkg::NUM_LANES];
    scs_pkg::sample_t res_re_next [scs_pkg::NUM_LANES];
    scs_pkg::sample_t res_im_next [scs_pkg::NUM_LANES];
    logic             sat_reg, sat_next;

    // Round half up, then clip to the signed sample range
    function automatic clip_res_t round_clip(input scs_pkg::acc_t acc);
        scs_pkg::acc_t biased;
        rnd_t          r;
        clip_res_t     res;
        biased = acc + ROUND_HALF;
        r      = $signed(biased[scs_pkg::ACC_BITS-1:scs_pkg::COEF_FRAC_BITS]);
        if (r > RND_MAX)
        begin
            res.value = scs_pkg::SAMPLE_MAX;
            res.clip  = 1'b1;
        end
        else if (r < RND_MIN)
        begin
            res.value = scs_pkg::SAMPLE_MIN;
            res.clip  = 1'b1;
        end
        else
        begin
            res.value = r[scs_pkg::SAMPLE_BITS-1:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

    // Round every part and merge the clip flags
    always_comb
    begin
        clip_res_t cr_re;
        clip_res_t cr_im;
        sat_next = 1'b0;
        for (int i = 0; i < scs_pkg::NUM_LANES; i++)
        begin
            cr_re          = round_clip(sum_re[i]);
            cr_im          = round_clip(sum_im[i]);
            res_re_next[i] = cr_re.value;
            res_im_next[i] = cr_im.value;
            sat_next       = sat_next | cr_re.clip | cr_im.clip;
        end
    end

    // Hold the result for the output strobe
    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        sat_reg    <= sat_next;
    end

    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign saturated = sat_reg;

endmodule

FILE: rtl/core/symmetrical_components_transform_core.sv
// ----------------------------------------------------------------------------
// symmetrical_components_transform_core: Fortescue transform of three phasors
// Multiplies a vector of three complex phasors by one of four constant
// symmetrical components matrices selected by the opcode.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode and the six phase parts and raise start; the transaction is
//   taken at the rising edge where start is high and busy is low. busy stays
//   low: the datapath is a fixed pipeline and takes one transaction every
//   cycle, so back-to-back starts are fine.
//   The result appears on out0..out2 and saturated for exactly one cycle,
//   flagged by done; the accepted transaction passes through the input
//   register, product register, sum register and output register, and done
//   rises with the result in the output register. Throughput is one
//   transaction per cycle; three parallel lanes each compute one output
//   phasor with ten multipliers, and the merge stage rounds and saturates.
//   The receiver cannot stall; results must be captured on the done cycle.
//   Reset clears the valid pipeline, so no done strobe follows reset until
//   a new transaction is started. Results are in transaction order.
// ----------------------------------------------------------------------------
module symmetrical_components_transform_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  scs_pkg::opcode_t        opcode,
    input  scs_pkg::sample_t        phase_a_re,
    input  scs_pkg::sample_t        phase_a_im,
    input  scs_pkg::sample_t        phase_b_re,
    input  scs_pkg::sample_t        phase_b_im,
    input  scs_pkg::sample_t        phase_c_re,
    input  scs_pkg::sample_t        phase_c_im,
    output logic                    done,
    output scs_pkg::sample_t        out0_re,
    output scs_pkg::sample_t        out0_im,
    output scs_pkg::sample_t        out1_re,
    output scs_pkg::sample_t        out1_im,
    output scs_pkg::sample_t        out2_re,
    output scs_pkg::sample_t        out2_im,
    output logic                    saturated
);

    logic                        accept;
    logic [scs_pkg::PIPE_DEPTH-1:0] vld_reg, vld_next;
    scs_pkg::coef_set_t          cs;
    scs_pkg::sample_t            xr_reg [3];
    scs_pkg::sample_t            xi_reg [3];
    scs_pkg::lane_coef_t         lc_reg [scs_pkg::NUM_LANES];
    scs_pkg::lane_coef_t         lc_next [scs_pkg::NUM_LANES];
    scs_pkg::acc_t               sum_re [scs_pkg::NUM_LANES];
    scs_pkg::acc_t               sum_im [scs_pkg::NUM_LANES];
    scs_pkg::sample_t            res_re [scs_pkg::NUM_LANES];
    scs_pkg::sample_t            res_im [scs_pkg::NUM_LANES];

    // Never hold off: the pipeline takes a transaction every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Build each lane's weights from the opcode's coefficient set
    always_comb
    begin
        cs = scs_pkg::coef_lookup(opcode);
        // first row: equal real weights
        lc_next[0].a    = cs.c1;
        lc_next[0].b_re = cs.c1;
        lc_next[0].b_im = '0;
        lc_next[0].c_re = cs.c1;
        lc_next[0].c_im = '0;
        // second row: w on phase b, conj(w) on phase c
        lc_next[1].a    = cs.c1;
        lc_next[1].b_re = cs.wr;
        lc_next[1].b_im = cs.wi;
        lc_next[1].c_re = cs.wr;
        lc_next[1].c_im = -cs.wi;
        // third row: conj(w) on phase b, w on phase c
        lc_next[2].a    = cs.c1;
        lc_next[2].b_re = cs.wr;
        lc_next[2].b_im = -cs.wi;
        lc_next[2].c_re = cs.wr;
        lc_next[2].c_im = cs.wi;
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xr_reg[0] <= phase_a_re;
            xi_reg[0] <= phase_a_im;
            xr_reg[1] <= phase_b_re;
            xi_reg[1] <= phase_b_im;
            xr_reg[2] <= phase_c_re;
            xi_reg[2] <= phase_c_im;
            lc_reg    <= lc_next;
        end
    end

    // Advance the valid marks alongside the datapath
    assign vld_next = {vld_reg[scs_pkg::PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // One lane per output phasor
    for (genvar g = 0; g < scs_pkg::NUM_LANES; g++)
    begin : g_lane
        scs_lane u_lane (
            .clk    (clk),
            .xr     (xr_reg),
            .xi     (xi_reg),
            .coef   (lc_reg[g]),
            .sum_re (sum_re[g]),
            .sum_im (sum_im[g])
        );
    end

    scs_merge u_merge (
        .clk       (clk),
        .sum_re    (sum_re),
        .sum_im    (sum_im),
        .res_re    (res_re),
        .res_im    (res_im),
        .saturated (saturated)
    );

    assign done    = vld_reg[scs_pkg::PIPE_DEPTH-1];
    assign out0_re = res_re[0];
    assign out0_im = res_im[0];
    assign out1_re = res_re[1];
    assign out1_im = res_im[1];
    assign out2_re = res_re[2];
    assign out2_im = res_im[2];

    // Every result strobe traces back to an earlier start
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, scs_pkg::PIPE_DEPTH))
        else $error("done without a matching start");

    // Every accepted transaction yields a result strobe
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted transaction lost");

    // A saturated result has at least one part on a rail
    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (out0_re == scs_pkg::SAMPLE_MAX || out0_re == scs_pkg::SAMPLE_MIN ||
             out0_im == scs_pkg::SAMPLE_MAX || out0_im == scs_pkg::SAMPLE_MIN ||
             out1_re == scs_pkg::SAMPLE_MAX || out1_re == scs_pkg::SAMPLE_MIN ||
             out1_im == scs_pkg::SAMPLE_MAX || out1_im == scs_pkg::SAMPLE_MIN ||
             out2_re == scs_pkg::SAMPLE_MAX || out2_re == scs_pkg::SAMPLE_MIN ||
             out2_im == scs_pkg::SAMPLE_MAX || out2_im == scs_pkg::SAMPLE_MIN))
        else $error("saturated flag set with no clipped part");

endmodule
